FILE: hdl/soc_pkg.sv
`timescale 1ns / 1ps

package soc_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int LEN_W       = 5;
	localparam int SYM_W       = 8;
	localparam int CNT_W       = 30;

	localparam logic [CNT_W-1:0] COUNT_MOD = CNT_W'(1000000007);

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_TEXT = 1'b1
	} req_type_t;

	// Broadcast from the top level to every cell of the row.
	typedef struct packed {
		logic             text_en;
		logic             clear;
		logic [SYM_W-1:0] sym;
	} cell_ctrl_t;

endpackage

FILE: hdl/soc_cell.sv
`timescale 1ns / 1ps

module soc_cell
	import soc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic             active,
	input  logic             load_en,
	input  logic [SYM_W-1:0] load_sym,
	input  logic [CNT_W-1:0] prev_count,
	output logic [CNT_W-1:0] count,
	output logic [CNT_W-1:0] count_next
);

	logic [SYM_W-1:0] char_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W:0]   sum;
	logic             match;

	always_ff @(posedge clk) begin
		if (load_en) begin
			char_q <= load_sym;
		end
	end

	assign match = active && ctrl.text_en && (char_q == ctrl.sym);
	assign sum   = {1'b0, count_q} + {1'b0, prev_count};

	// Add the left neighbor's count, fold once by the modulus.
	always_comb begin
		count_next = count_q;
		if (match) begin
			if (sum >= {1'b0, COUNT_MOD}) begin
				count_next = CNT_W'(sum - {1'b0, COUNT_MOD});
			end else begin
				count_next = sum[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.text_en) begin
			count_q <= count_next;
		end
	end

	assign count = count_q;

endmodule

FILE: hdl/subsequence_occurrence_counter_core.sv
`timescale 1ns / 1ps

// Subsequence occurrence counter.
// Load the pattern first: each input word with req_type = 0 writes symbol at
// pattern_index. Write the number of pattern characters in use through the
// cfg channel (cfg_ready is always high; 0 acts as 1, above 16 acts as 16).
// Then stream text words with req_type = 1, one character per word. The word
// with last_text = 1 yields one output word, occurrence_count, the number of
// times the pattern occurs as a subsequence of the text, modulo 1000000007,
// and clears the counts for the next stream. Load words give no output.
// A row of 16 cells, one per pattern position, updates all prefix counts in
// the cycle the text word is accepted; each cell takes its left neighbor's
// count from before that word. Throughput: one input word per cycle while
// not stalled; the count is output in the cycle after the last word.
// When the receiver stalls, the output register holds its word and in_ready
// drops until it is taken; words that give no output are blocked as well.
// Reset clears the counts, sets the length to 1 and empties the output; the
// pattern symbols are undefined until loaded.

module subsequence_occurrence_counter_core
	import soc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] pattern_length,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [IDX_W-1:0] pattern_index,
	input  logic [SYM_W-1:0] symbol,
	input  logic             last_text,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] occurrence_count
);

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_eff;
	logic [IDX_W-1:0] sel;
	logic             out_valid_q;
	logic [CNT_W-1:0] occurrence_count_q;
	logic             in_fire;
	logic             text_fire;
	logic             load_fire;
	cell_ctrl_t       ctrl;

	logic [CNT_W-1:0] counts     [MAX_PATTERN];
	logic [CNT_W-1:0] counts_nxt [MAX_PATTERN];

	// Length register; configuration is never stalled.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(1);
		end else if (cfg_valid) begin
			len_q <= pattern_length;
		end
	end

	// Saturate the length into 1..MAX_PATTERN.
	always_comb begin
		len_eff = len_q;
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > LEN_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end
	end

	assign sel = IDX_W'(len_eff - LEN_W'(1));

	// Take a new word while the output is empty or being drained.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign text_fire = in_fire && (req_type_t'(req_type) == REQ_TEXT);
	assign load_fire = in_fire && (req_type_t'(req_type) == REQ_LOAD);

	assign ctrl.text_en = text_fire;
	assign ctrl.clear   = text_fire && last_text;
	assign ctrl.sym     = symbol;

	// Row of cells: each position adds the count handed over from its left.
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [CNT_W-1:0] prev;
		logic             load_en;

		if (k == 0) begin : g_first
			assign prev = CNT_W'(1);
		end else begin : g_rest
			assign prev = counts[k-1];
		end

		assign load_en = load_fire && ({1'b0, pattern_index} == (IDX_W+1)'(k));

		soc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.active     (LEN_W'(k) < len_eff),
			.load_en    (load_en),
			.load_sym   (symbol),
			.prev_count (prev),
			.count      (counts[k]),
			.count_next (counts_nxt[k])
		);
	end

	// Output register: capture the updated count of the last pattern position in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			occurrence_count_q <= counts_nxt[sel];
		end
	end

	assign out_valid        = out_valid_q;
	assign occurrence_count = occurrence_count_q;

endmodule

FILE: hdl/soc_checker.sv
`timescale 1ns / 1ps

module soc_checker
	import soc_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             req_type,
	input logic             last_text,
	input logic             out_valid,
	input logic             out_ready,
	input logic [CNT_W-1:0] occurrence_count
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(occurrence_count))
		else $error("output word changed while stalled");

	// The output count stays reduced.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occurrence_count < COUNT_MOD)
		else $error("count not reduced");

	// A new output word only follows an accepted last text word.
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && req_type && last_text))
		else $error("output word without last text word");

	// No input is taken while the output is stalled.
	a_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

endmodule

bind subsequence_occurrence_counter_core soc_checker u_soc_checker (.*);
